[rtl/fcr_pkg.sv]
// ----------------------------------------------------------------------------
// fcr_pkg
// shared widths, register indexes and result codes of the cluster chain reader
// ----------------------------------------------------------------------------
package fcr_pkg;

  // address width of the request beats
  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned CLUSTER_W  = 28;
  localparam int unsigned LEFT_W     = 23;
  localparam int unsigned LEN_W      = 17;
  localparam int unsigned SIZE_W     = 31;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned PROD_W     = CLUSTER_W + LEN_W;
  localparam int unsigned DIV_CNT_W  = $clog2(SIZE_W);

  localparam logic [LEN_W-1:0] MIN_CLUSTER_BYTES = LEN_W'(512);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FAT32_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAT_START     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_START    = 2'd3;

  // result beat kinds
  localparam logic [KIND_W-1:0] KIND_DATA        = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TABLE       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DONE        = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BAD_SIZE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BAD_CLUSTER = 3'd4;

  // input operations
  localparam logic OP_START = 1'b0;
  localparam logic OP_ENTRY = 1'b1;

endpackage

[rtl/fat_cluster_chain_reader_unit.sv]
// ----------------------------------------------------------------------------
// fat_cluster_chain_reader_unit
// sequence: a start beat that passes its checks runs 31 restoring divide
//   steps and one multiply before its data beat; an entry beat runs the
//   multiply and then its data beat; a rejected beat gives a single beat
// the input stalls while any beat is in progress, so a new start or entry
//   beat is taken only once the sequencer is back in idle
// reset: configuration returns to its defaults and any chain walk is dropped
// ----------------------------------------------------------------------------
module fat_cluster_chain_reader_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [fcr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fcr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            operation_i,
  input  logic [15:0]                     start_low_i,
  input  logic [15:0]                     start_high_i,
  input  logic [31:0]                     file_bytes_i,
  input  logic [31:0]                     table_entry_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [fcr_pkg::KIND_W-1:0]      kind_o,
  output logic [fcr_pkg::ADDR_W-1:0]      address_o,
  output logic [fcr_pkg::LEN_W-1:0]       length_o,
  output logic                            last_o
);
  import fcr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_DATA,
    ST_LAST,
    ST_ONE
  } state_e;

  // configuration registers
  logic                  fat32_q;
  logic [LEN_W-1:0]      cluster_bytes_q;
  logic [31:0]           fat_start_q;
  logic [31:0]           data_start_q;

  // walk state
  state_e                state_q;
  logic                  busy_q;
  logic [CLUSTER_W-1:0]  cur_q;
  logic [LEFT_W-1:0]     left_q;
  logic [LEN_W-1:0]      tail_q;
  logic [KIND_W-1:0]     pend_kind_q;

  // divider: dvd_q shifts the dividend out and the quotient in
  logic [SIZE_W-1:0]     dvd_q;
  logic [LEN_W-1:0]      rem_q;
  logic [DIV_CNT_W-1:0]  cnt_q;

  logic [PROD_W-1:0]     prod_q;

  // output register
  logic                  out_valid_q;
  logic [KIND_W-1:0]     kind_q;
  logic [ADDR_W-1:0]     address_q;
  logic [LEN_W-1:0]      length_q;
  logic                  last_q;

  logic                  in_take;
  logic                  slot_free;
  logic [LEN_W-1:0]      cb_eff;
  logic [CLUSTER_W-1:0]  start_cl;
  logic [CLUSTER_W-1:0]  entry_cl;
  logic [LEN_W:0]        trial;
  logic [LEN_W:0]        diff;
  logic                  qbit;
  logic [LEN_W-1:0]      rem_next;
  logic [SIZE_W-1:0]     dvd_next;
  logic [ADDR_W-1:0]     data_addr;
  logic [ADDR_W-1:0]     table_addr;
  logic [LEN_W-1:0]      entry_len;
  logic [CLUSTER_W-1:0]  cl_off;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign address_o   = address_q;
  assign length_o    = length_q;
  assign last_o      = last_q;

  // sizes below the sector size count as one sector
  assign cb_eff = (cluster_bytes_q < MIN_CLUSTER_BYTES) ? MIN_CLUSTER_BYTES : cluster_bytes_q;

  // first cluster: high half only takes part in fat32 mode, masked to 28 bits
  assign start_cl = fat32_q ? {start_high_i[CLUSTER_W-17:0], start_low_i}
                            : {{(CLUSTER_W-16){1'b0}}, start_low_i};
  assign entry_cl = fat32_q ? table_entry_i[CLUSTER_W-1:0]
                            : {{(CLUSTER_W-16){1'b0}}, table_entry_i[15:0]};

  // one restoring divide step: the subtractor of the divider
  assign trial    = {rem_q, dvd_q[SIZE_W-1]};
  assign diff     = trial - {1'b0, cb_eff};
  assign qbit     = !diff[LEN_W];
  assign rem_next = qbit ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
  assign dvd_next = {dvd_q[SIZE_W-2:0], qbit};

  // request addresses, wrapped to the address width
  assign cl_off     = cur_q - CLUSTER_W'(2);
  assign data_addr  = ADDR_W'(data_start_q) + ADDR_W'(prod_q);
  assign entry_len  = fat32_q ? LEN_W'(4) : LEN_W'(2);
  assign table_addr = ADDR_W'(fat_start_q)
                    + (fat32_q ? (ADDR_W'(cur_q) << 2) : (ADDR_W'(cur_q) << 1));

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fat32_q         <= 1'b0;
      cluster_bytes_q <= MIN_CLUSTER_BYTES;
      fat_start_q     <= '0;
      data_start_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FAT32_MODE:    fat32_q         <= cfg_data_i[0];
        REG_CLUSTER_BYTES: cluster_bytes_q <= cfg_data_i[LEN_W-1:0];
        REG_FAT_START:     fat_start_q     <= cfg_data_i;
        REG_DATA_START:    data_start_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer, walk state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      busy_q      <= 1'b0;
      cur_q       <= '0;
      left_q      <= '0;
      tail_q      <= '0;
      pend_kind_q <= KIND_DONE;
      dvd_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_DONE;
      address_q   <= '0;
      length_q    <= '0;
      last_q      <= 1'b0;
    end else begin
      // a taken beat frees the slot unless refilled below
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            if (operation_i == OP_START) begin
              // a new start drops any walk in progress
              busy_q <= 1'b0;
              if (file_bytes_i[31]) begin
                pend_kind_q <= KIND_BAD_SIZE;
                state_q     <= ST_ONE;
              end else if (file_bytes_i == '0) begin
                pend_kind_q <= KIND_DONE;
                state_q     <= ST_ONE;
              end else if (start_cl < CLUSTER_W'(2)) begin
                pend_kind_q <= KIND_BAD_CLUSTER;
                state_q     <= ST_ONE;
              end else begin
                cur_q   <= start_cl;
                dvd_q   <= file_bytes_i[SIZE_W-1:0];
                rem_q   <= '0;
                cnt_q   <= '0;
                state_q <= ST_DIV;
              end
            end else if (busy_q && (left_q != '0)) begin
              // entry beats while no walk is waiting are dropped silently
              if (entry_cl < CLUSTER_W'(2)) begin
                busy_q      <= 1'b0;
                pend_kind_q <= KIND_BAD_CLUSTER;
                state_q     <= ST_ONE;
              end else begin
                cur_q   <= entry_cl;
                left_q  <= left_q - LEFT_W'(1);
                state_q <= ST_MUL;
              end
            end
          end
        end

        ST_DIV: begin
          dvd_q <= dvd_next;
          rem_q <= rem_next;
          cnt_q <= cnt_q + DIV_CNT_W'(1);
          if (cnt_q == DIV_CNT_W'(SIZE_W - 1)) begin
            // clusters after the first, and the bytes in the last cluster
            left_q  <= (rem_next != '0) ? dvd_next[LEFT_W-1:0]
                                        : dvd_next[LEFT_W-1:0] - LEFT_W'(1);
            tail_q  <= (rem_next != '0) ? rem_next : cb_eff;
            state_q <= ST_MUL;
          end
        end

        ST_MUL: begin
          prod_q  <= PROD_W'(cl_off) * PROD_W'(cb_eff);
          state_q <= ST_DATA;
        end

        ST_DATA: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            kind_q      <= KIND_DATA;
            address_q   <= data_addr;
            length_q    <= (left_q == '0) ? tail_q : cb_eff;
            last_q      <= 1'b0;
            state_q     <= ST_LAST;
          end
        end

        ST_LAST: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            last_q      <= 1'b1;
            if (left_q == '0) begin
              // chain complete
              busy_q    <= 1'b0;
              kind_q    <= KIND_DONE;
              address_q <= '0;
              length_q  <= '0;
            end else begin
              // ask for the table entry of the current cluster
              busy_q    <= 1'b1;
              kind_q    <= KIND_TABLE;
              address_q <= table_addr;
              length_q  <= entry_len;
            end
            state_q <= ST_IDLE;
          end
        end

        ST_ONE: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            kind_q      <= pend_kind_q;
            address_q   <= '0;
            length_q    <= '0;
            last_q      <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
